### rtl/loco_record_table_macros.svh
// ----------------------------------------------------------------------------
// loco_record_table_macros: assertion helpers for the record table checker
// Each macro expects signals named clk and rst in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef LOCO_RECORD_TABLE_MACROS_SVH
`define LOCO_RECORD_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define LRT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define LRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lrt_pkg.sv
// ----------------------------------------------------------------------------
// lrt_pkg: shared types and constants of the record table
// Payload structs, operation codes and controller/datapath interface.
// ----------------------------------------------------------------------------
package lrt_pkg;

  localparam int ENTRIES_DEF  = 64;
  localparam int NAME_LEN_DEF = 10;
  localparam int ADDR_W       = 14;
  localparam int FMT_W        = 2;
  localparam int KEY_W        = FMT_W + ADDR_W;
  localparam int CHAR_W       = 8;
  localparam int USED_W       = 7;
  localparam logic [FMT_W-1:0] DEFAULT_FORMAT_RST = 2'd2;

  localparam logic [2:0] OP_GET_FMT   = 3'd0;
  localparam logic [2:0] OP_GET_NAME  = 3'd1;
  localparam logic [2:0] OP_STORE_FMT = 3'd2;
  localparam logic [2:0] OP_STORE_CHR = 3'd3;
  localparam logic [2:0] OP_CLEAR     = 3'd4;
  localparam logic [2:0] OP_NEXT      = 3'd5;
  localparam logic [2:0] OP_REWIND    = 3'd6;

  typedef struct packed {
    logic [2:0]        op;
    logic [ADDR_W-1:0] loco_address;
    logic [FMT_W-1:0]  new_format;
    logic [3:0]        name_position;
    logic [CHAR_W-1:0] name_byte;
    logic              name_end;
  } lrt_in_t;

  typedef struct packed {
    logic              success;
    logic [FMT_W-1:0]  format_out;
    logic [ADDR_W-1:0] found_address;
    logic [CHAR_W-1:0] char_out;
    logic              run_last;
    logic [USED_W-1:0] entries_used;
  } lrt_out_t;

  // Result kinds loaded into the output register
  typedef enum logic [2:0] {
    RES_FAIL,
    RES_OK,
    RES_HIT,
    RES_STORE,
    RES_CHAR
  } res_t;

  // Name write kinds
  typedef enum logic [1:0] {
    NW_BASE_ZERO,
    NW_POS_BYTE,
    NW_END_ZERO
  } nw_t;

  typedef struct packed {
    logic take;
    logic scan_start;
    logic clr_en;
    logic clr_keys_only;
    logic count_clr;
    logic count_inc;
    logic key_wr;
    logic name_wr;
    nw_t  name_sel;
    logic cur_next;
    logic cur_zero;
    logic j_clr;
    logic j_inc;
    logic load_out;
    res_t res_sel;
    logic res_last;
  } lrt_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       found;
    logic       avail;
    logic       scan_busy;
    logic       clr_last;
    logic       pos_ok;
    logic       name_end;
    logic       key_zero;
    logic       char_last;
    logic       out_busy;
  } lrt_stat_t;

endpackage

### rtl/lrt_ram.sv
// ----------------------------------------------------------------------------
// lrt_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/lrt_datapath.sv
// ----------------------------------------------------------------------------
// lrt_datapath: stores, scan pipeline and output register of the table
// Runs the entry scan, the clear sweep, the writes and the result loads.
// ----------------------------------------------------------------------------
module lrt_datapath #(
  parameter int ENTRIES  = lrt_pkg::ENTRIES_DEF,
  parameter int NAME_LEN = lrt_pkg::NAME_LEN_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  lrt_pkg::lrt_in_t         in_data,
  output lrt_pkg::lrt_out_t        out_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  input  logic                     cfg_wr_en,
  input  logic [lrt_pkg::FMT_W-1:0] cfg_wr_data,
  input  lrt_pkg::lrt_cmd_t        cmd,
  output lrt_pkg::lrt_stat_t       stat
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int NA_W  = $clog2(ENTRIES * NAME_LEN);
  localparam int J_W   = $clog2(NAME_LEN);
  localparam int AW    = lrt_pkg::ADDR_W;
  localparam int FW    = lrt_pkg::FMT_W;
  localparam int KW    = lrt_pkg::KEY_W;

  lrt_pkg::lrt_in_t        item;
  logic [FW-1:0]           default_format;
  logic [CNT_W-1:0]        cursor;
  logic [CNT_W-1:0]        count;
  logic [NA_W-1:0]         clr_cnt;
  logic                    issuing;
  logic                    pend;
  logic [IDX_W-1:0]        ridx;
  logic [NA_W-1:0]         rbase;
  logic [IDX_W-1:0]        pidx;
  logic [NA_W-1:0]         pbase;
  logic                    match_found;
  logic [IDX_W-1:0]        match_idx;
  logic [NA_W-1:0]         match_base;
  logic [KW-1:0]           match_word;
  logic                    empty_found;
  logic [IDX_W-1:0]        empty_idx;
  logic [NA_W-1:0]         empty_base;
  logic [J_W-1:0]          j;

  logic [IDX_W-1:0]        tgt_idx;
  logic [NA_W-1:0]         tgt_base;
  logic                    key_we;
  logic [IDX_W-1:0]        key_waddr;
  logic [KW-1:0]           key_wdata;
  logic [KW-1:0]           key_rdata;
  logic                    name_we;
  logic [NA_W-1:0]         name_waddr;
  logic [7:0]              name_wdata;
  logic [NA_W-1:0]         name_raddr;
  logic [7:0]              name_rdata;
  logic                    is_hit;
  logic                    is_empty;
  logic                    clr_last;
  lrt_pkg::lrt_out_t       res;
  logic [FW-1:0]           store_fmt;
  logic [lrt_pkg::USED_W-1:0] used_sat;

  assign tgt_idx    = match_found ? match_idx : empty_idx;
  assign tgt_base   = match_found ? match_base : empty_base;
  assign name_raddr = tgt_base + NA_W'(j);

  // compare the word coming back from the key store
  always_comb begin
    if (item.op == lrt_pkg::OP_NEXT) begin
      is_hit = (key_rdata[AW-1:0] != '0) && (32'(pidx) >= 32'(cursor));
    end else begin
      is_hit = (key_rdata[AW-1:0] == item.loco_address);
    end
    is_empty = (key_rdata == '0);
  end

  assign clr_last = cmd.clr_keys_only ? (32'(clr_cnt) == ENTRIES - 1)
                                      : (32'(clr_cnt) == ENTRIES * NAME_LEN - 1);

  // key store write port: clear sweep or entry update
  always_comb begin
    if (cmd.clr_en) begin
      key_we    = (32'(clr_cnt) < ENTRIES);
      key_waddr = clr_cnt[IDX_W-1:0];
      key_wdata = '0;
    end else begin
      key_we    = cmd.key_wr;
      key_waddr = tgt_idx;
      key_wdata = (item.op == lrt_pkg::OP_STORE_FMT) ?
                  {item.new_format, item.loco_address} :
                  {default_format, item.loco_address};
    end
  end

  // name store write port
  always_comb begin
    name_we    = cmd.name_wr;
    name_waddr = tgt_base;
    name_wdata = '0;
    if (cmd.clr_en) begin
      name_we    = !cmd.clr_keys_only;
      name_waddr = clr_cnt;
    end else begin
      unique case (cmd.name_sel)
        lrt_pkg::NW_BASE_ZERO: name_waddr = tgt_base;
        lrt_pkg::NW_POS_BYTE: begin
          name_waddr = tgt_base + NA_W'(item.name_position);
          name_wdata = item.name_byte;
        end
        lrt_pkg::NW_END_ZERO: name_waddr = tgt_base + NA_W'(NAME_LEN - 1);
        default: name_waddr = tgt_base;
      endcase
    end
  end

  lrt_ram #(.WIDTH(KW), .DEPTH(ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (ridx),
    .rdata (key_rdata)
  );

  lrt_ram #(.WIDTH(8), .DEPTH(ENTRIES * NAME_LEN)) u_name_ram (
    .clk   (clk),
    .we    (name_we),
    .waddr (name_waddr),
    .wdata (name_wdata),
    .raddr (name_raddr),
    .rdata (name_rdata)
  );

  // result fields per kind
  assign store_fmt = (item.op == lrt_pkg::OP_STORE_FMT) ? item.new_format :
                     (match_found ? match_word[KW-1:AW] : default_format);
  assign used_sat  = (32'(count) > 32'd127) ? 7'd127 : 7'(count);

  always_comb begin
    res = '0;
    res.run_last     = cmd.res_last;
    res.entries_used = used_sat;
    res.format_out   = default_format;
    unique case (cmd.res_sel)
      lrt_pkg::RES_FAIL: res.success = 1'b0;
      lrt_pkg::RES_OK:   res.success = 1'b1;
      lrt_pkg::RES_HIT: begin
        res.success       = 1'b1;
        res.format_out    = match_word[KW-1:AW];
        res.found_address = item.loco_address;
      end
      lrt_pkg::RES_STORE: begin
        res.success       = 1'b1;
        res.format_out    = store_fmt;
        res.found_address = item.loco_address;
      end
      lrt_pkg::RES_CHAR: begin
        res.success       = 1'b1;
        res.format_out    = match_word[KW-1:AW];
        res.found_address = match_word[AW-1:0];
        res.char_out      = name_rdata;
      end
      default: res.success = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      default_format <= lrt_pkg::DEFAULT_FORMAT_RST;
      cursor         <= '0;
      count          <= '0;
      clr_cnt        <= '0;
      issuing        <= 1'b0;
      pend           <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        default_format <= cfg_wr_data;
      end
      if (cmd.clr_en) begin
        clr_cnt <= clr_last ? '0 : clr_cnt + NA_W'(1);
      end
      // advance or zero the cursor
      if (cmd.cur_next) begin
        cursor <= CNT_W'(match_idx) + CNT_W'(1);
      end else if (cmd.cur_zero) begin
        cursor <= '0;
      end
      if (cmd.count_clr) begin
        count <= '0;
      end else if (cmd.count_inc) begin
        count <= count + CNT_W'(1);
      end
      // scan issue and return flags
      if (cmd.scan_start) begin
        issuing <= 1'b1;
      end else if (issuing && (32'(ridx) == ENTRIES - 1)) begin
        issuing <= 1'b0;
      end
      pend <= issuing;
      // output register handshake
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item <= in_data;
    end
    if (cmd.load_out) begin
      out_data <= res;
    end
    if (cmd.j_clr) begin
      j <= '0;
    end else if (cmd.j_inc) begin
      j <= j + J_W'(1);
    end
    if (cmd.scan_start) begin
      ridx        <= '0;
      rbase       <= '0;
      match_found <= 1'b0;
      empty_found <= 1'b0;
    end else begin
      if (issuing) begin
        ridx  <= ridx + IDX_W'(1);
        rbase <= rbase + NA_W'(NAME_LEN);
      end
      // keep the first hit and the first empty entry
      if (pend) begin
        if (is_hit && !match_found) begin
          match_found <= 1'b1;
          match_idx   <= pidx;
          match_base  <= pbase;
          match_word  <= key_rdata;
        end
        if (is_empty && !empty_found) begin
          empty_found <= 1'b1;
          empty_idx   <= pidx;
          empty_base  <= pbase;
        end
      end
    end
    pidx  <= ridx;
    pbase <= rbase;
  end

  // status to the controller
  always_comb begin
    stat.op        = item.op;
    stat.found     = match_found;
    stat.avail     = match_found || empty_found;
    stat.scan_busy = issuing || pend;
    stat.clr_last  = clr_last;
    stat.pos_ok    = (32'(item.name_position) < NAME_LEN);
    stat.name_end  = item.name_end;
    stat.key_zero  = (item.loco_address == '0);
    stat.char_last = (name_rdata == '0) || (32'(j) == NAME_LEN - 1);
    stat.out_busy  = out_valid;
  end

endmodule

### rtl/lrt_ctrl.sv
// ----------------------------------------------------------------------------
// lrt_ctrl: operation sequencer of the record table
// Steps each operation through scan, writes and result transfers.
// ----------------------------------------------------------------------------
module lrt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lrt_pkg::lrt_stat_t stat,
  output lrt_pkg::lrt_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DISP,
    S_SCAN,
    S_CLR,
    S_ACT,
    S_WR2,
    S_RES,
    S_NRD,
    S_NDATA,
    S_OWAIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   more;
  logic   more_next;

  assign in_ready = (state == S_IDLE);

  // commands and next state
  always_comb begin
    cmd        = '0;
    cmd.take   = in_valid && in_ready;
    state_next = state;
    more_next  = more;
    unique case (state)
      S_INIT: begin
        cmd.clr_en = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        cmd.res_last = 1'b1;
        priority if (stat.op == lrt_pkg::OP_CLEAR) begin
          state_next = S_CLR;
        end else if (stat.op == lrt_pkg::OP_REWIND) begin
          cmd.cur_zero = 1'b1;
          cmd.load_out = 1'b1;
          cmd.res_sel  = lrt_pkg::RES_OK;
          state_next   = S_OWAIT;
        end else if (stat.op == lrt_pkg::OP_GET_FMT || stat.op == lrt_pkg::OP_GET_NAME ||
                     stat.op == lrt_pkg::OP_STORE_FMT ||
                     stat.op == lrt_pkg::OP_STORE_CHR || stat.op == lrt_pkg::OP_NEXT) begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end else begin
          cmd.load_out = 1'b1;
          cmd.res_sel  = lrt_pkg::RES_FAIL;
          state_next   = S_OWAIT;
        end
      end
      S_SCAN: begin
        if (!stat.scan_busy) begin
          state_next = S_ACT;
        end
      end
      S_CLR: begin
        cmd.clr_en        = 1'b1;
        cmd.clr_keys_only = 1'b1;
        if (stat.clr_last) begin
          cmd.count_clr = 1'b1;
          state_next    = S_ACT;
        end
      end
      S_ACT: begin
        cmd.res_last = 1'b1;
        cmd.res_sel  = lrt_pkg::RES_FAIL;
        cmd.j_clr    = 1'b1;
        unique case (stat.op)
          lrt_pkg::OP_CLEAR: begin
            cmd.load_out = 1'b1;
            cmd.res_sel  = lrt_pkg::RES_OK;
            state_next   = S_OWAIT;
          end
          lrt_pkg::OP_GET_FMT: begin
            cmd.load_out = 1'b1;
            cmd.res_sel  = stat.found ? lrt_pkg::RES_HIT : lrt_pkg::RES_FAIL;
            state_next   = S_OWAIT;
          end
          lrt_pkg::OP_GET_NAME, lrt_pkg::OP_NEXT: begin
            if (stat.found) begin
              cmd.cur_next = (stat.op == lrt_pkg::OP_NEXT);
              state_next   = S_NRD;
            end else begin
              cmd.cur_zero = (stat.op == lrt_pkg::OP_NEXT);
              cmd.load_out = 1'b1;
              state_next   = S_OWAIT;
            end
          end
          lrt_pkg::OP_STORE_FMT: begin
            if (stat.avail) begin
              cmd.key_wr    = 1'b1;
              cmd.name_wr   = !stat.found;
              cmd.name_sel  = lrt_pkg::NW_BASE_ZERO;
              cmd.count_inc = !stat.found && !stat.key_zero;
              state_next    = S_RES;
            end else begin
              cmd.load_out = 1'b1;
              state_next   = S_OWAIT;
            end
          end
          lrt_pkg::OP_STORE_CHR: begin
            if (stat.avail) begin
              cmd.key_wr    = !stat.found;
              cmd.name_wr   = stat.pos_ok;
              cmd.name_sel  = lrt_pkg::NW_POS_BYTE;
              cmd.count_inc = !stat.found && !stat.key_zero;
              state_next    = stat.name_end ? S_WR2 : S_RES;
            end else begin
              cmd.load_out = 1'b1;
              state_next   = S_OWAIT;
            end
          end
          default: begin
            cmd.load_out = 1'b1;
            state_next   = S_OWAIT;
          end
        endcase
      end
      S_WR2: begin
        cmd.name_wr  = 1'b1;
        cmd.name_sel = lrt_pkg::NW_END_ZERO;
        state_next   = S_RES;
      end
      S_RES: begin
        cmd.load_out = 1'b1;
        cmd.res_sel  = lrt_pkg::RES_STORE;
        cmd.res_last = 1'b1;
        state_next   = S_OWAIT;
      end
      S_NRD: begin
        state_next = S_NDATA;
      end
      S_NDATA: begin
        cmd.load_out = 1'b1;
        cmd.res_sel  = lrt_pkg::RES_CHAR;
        cmd.res_last = stat.char_last;
        cmd.j_inc    = !stat.char_last;
        more_next    = !stat.char_last;
        state_next   = S_OWAIT;
      end
      S_OWAIT: begin
        // hold until the result transfer completes
        if (!stat.out_busy) begin
          state_next = more ? S_NRD : S_IDLE;
          more_next  = 1'b0;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and registered flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      more  <= 1'b0;
    end else begin
      state <= state_next;
      more  <= more_next;
    end
  end

endmodule

### rtl/loco_record_table.sv
// A lookup or store scans all ENTRIES words of the key store before its result is loaded.
// Name results follow one byte per result: a name store read, then the result transfer.
// Clear sweeps the key store; rewind and bad codes answer without a scan.
// One item is worked on at a time; the next is taken after the last result transfer.
// Reset (rst, synchronous) runs a clearing pass over the key and name stores, no item taken.
// ----------------------------------------------------------------------------
// loco_record_table: keyed table of format words and short names
// Controller and datapath joined by command and status structs.
// ----------------------------------------------------------------------------
module loco_record_table #(
  parameter int ENTRIES  = lrt_pkg::ENTRIES_DEF,
  parameter int NAME_LEN = lrt_pkg::NAME_LEN_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  lrt_pkg::lrt_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output lrt_pkg::lrt_out_t         out_data,
  input  logic                      cfg_wr_en,
  input  logic [lrt_pkg::FMT_W-1:0] cfg_wr_data
);

  lrt_pkg::lrt_cmd_t  cmd;
  lrt_pkg::lrt_stat_t stat;

  lrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lrt_datapath #(.ENTRIES(ENTRIES), .NAME_LEN(NAME_LEN)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_data     (in_data),
    .out_data    (out_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

### rtl/lrt_checker.sv
// ----------------------------------------------------------------------------
// lrt_checker: port-level checks of the record table
// Bound to the top level; watches handshake and result ordering.
// ----------------------------------------------------------------------------
`include "loco_record_table_macros.svh"

module lrt_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input lrt_pkg::lrt_out_t out_data
);

  // a stalled result holds
  `LRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // no new item while a result waits
  `LRT_ASSERT_NOW(a_busy_out, out_valid, !in_ready, "input taken while result pending")

  // an accepted item keeps the block busy for the next cycle
  `LRT_ASSERT_NEXT(a_busy_in, in_valid && in_ready, !in_ready, "ready right after a transfer")

  // a failure is always the single result of its item
  `LRT_ASSERT_NOW(a_fail_last, out_valid && !out_data.success, out_data.run_last, "failure not last")

endmodule

bind loco_record_table lrt_checker u_lrt_checker (.*);
